FILE: design/edf_tick_scheduler_core_macros.svh
// Assertion helpers shared by the scheduler modules.
`ifndef EDF_TICK_SCHEDULER_CORE_MACROS_SVH
`define EDF_TICK_SCHEDULER_CORE_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define EDFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define EDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (i_rst_n && (ante)) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/edfs_pkg.sv
package edfs_pkg;

    localparam int DEF_NUM_TASKS = 8;
    localparam int DEF_TIME_BITS = 32;

    localparam int FIELD_BITS    = 16;
    localparam int SLOT_BITS     = 32;
    localparam int COUNT_BITS    = 4;
    localparam int TASK_IDX_BITS = 3;
    localparam int OUT_TASK_BITS = 4;
    localparam int PICK_IDX_BITS = 6;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [COUNT_BITS-1:0] RESET_TASK_COUNT = 4'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_TASK_COUNT = 1'b0;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_COMMIT
    } t_seq_state;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_BUSY,
        TOP_DONE
    } t_top_state;

    typedef struct packed {
        logic                     start;
        logic                     load;
        logic [TASK_IDX_BITS-1:0] idx;
        logic [FIELD_BITS-1:0]    period;
        logic [FIELD_BITS-1:0]    exec_time;
        logic [COUNT_BITS-1:0]    count;
        logic                     failed;
    } t_seq_req;

    typedef struct packed {
        logic                     done;
        logic                     fail;
        logic                     found;
        logic [PICK_IDX_BITS-1:0] pick_idx;
    } t_seq_rsp;

endpackage

FILE: design/edfs_entry_ram.sv
module edfs_entry_ram
    import edfs_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_TASKS,
    parameter int WIDTH  = DEF_TIME_BITS + 3 * FIELD_BITS,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/edfs_seq.sv
`include "edf_tick_scheduler_core_macros.svh"

module edfs_seq
    import edfs_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_seq_req             i_req,
    input  logic [TIME_BITS-1:0] i_time,
    output t_seq_rsp             o_rsp
);

    localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W  = $clog2(NUM_TASKS + 1);
    localparam int ENT_W  = TIME_BITS + 3 * FIELD_BITS;
    localparam int DL_LO  = 0;
    localparam int REM_LO = TIME_BITS;
    localparam int EXE_LO = TIME_BITS + FIELD_BITS;
    localparam int PER_LO = TIME_BITS + 2 * FIELD_BITS;

    t_seq_state r_state, n_state;

    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_issue;
    logic             r_fail;
    logic             r_b_valid;
    logic [IDX_W-1:0] r_b_idx;
    logic             r_c_valid;
    logic [IDX_W-1:0] r_c_idx;
    logic [ENT_W-1:0] r_c_ent;
    logic             r_best_valid;
    logic [IDX_W-1:0] r_best_idx;
    logic [ENT_W-1:0] r_best_ent;

    logic [ENT_W-1:0]           rd_data;
    logic                       rd_en;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ENT_W-1:0]           wr_data;
    logic [TIME_BITS-1:0]       b_dl;
    logic [FIELD_BITS-1:0]      b_rem;
    logic [FIELD_BITS-1:0]      b_exe;
    logic [FIELD_BITS-1:0]      b_per;
    logic [TIME_BITS:0]         b_sum;
    logic                       b_hit;
    logic                       b_miss;
    logic [ENT_W-1:0]           b_new;
    logic                       c_take;
    logic [CNT_W+COUNT_BITS-1:0] count_ext;
    logic [CNT_W-1:0]           act_cnt;
    logic [IDX_W+TASK_IDX_BITS-1:0] idx_ext;
    logic [ENT_W-1:0]           load_ent;
    logic [ENT_W-1:0]           commit_ent;
    logic                       tick_start;

    edfs_entry_ram #(
        .DEPTH  (NUM_TASKS),
        .WIDTH  (ENT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign tick_start = (r_state == SEQ_IDLE) && i_req.start && !i_req.load;
    assign rd_en      = (r_state == SEQ_SCAN) && (r_issue != r_n);

    assign count_ext = {{CNT_W{1'b0}}, i_req.count};
    assign act_cnt   = (count_ext > (CNT_W + COUNT_BITS)'(NUM_TASKS)) ?
                       CNT_W'(NUM_TASKS) : count_ext[CNT_W-1:0];
    assign idx_ext   = {{IDX_W{1'b0}}, i_req.idx};
    assign load_ent  = {i_req.period, i_req.exec_time, i_req.exec_time,
                        TIME_BITS'(i_req.period)};

    // release check on the entry just read
    always_comb begin
        b_dl   = rd_data[DL_LO +: TIME_BITS];
        b_rem  = rd_data[REM_LO +: FIELD_BITS];
        b_exe  = rd_data[EXE_LO +: FIELD_BITS];
        b_per  = rd_data[PER_LO +: FIELD_BITS];
        b_sum  = {1'b0, b_dl} + (TIME_BITS + 1)'(b_per);
        b_hit  = r_b_valid && !r_fail && (b_dl == i_time);
        b_new  = rd_data;
        b_miss = 1'b0;
        if (b_hit) begin
            if (b_sum[TIME_BITS]) begin
                b_new[DL_LO +: TIME_BITS] = '1;
                b_miss = 1'b1;
            end else begin
                b_new[DL_LO +: TIME_BITS] = b_sum[TIME_BITS-1:0];
                if (b_rem != '0) begin
                    b_miss = 1'b1;
                end else begin
                    b_new[REM_LO +: FIELD_BITS] = b_exe;
                end
            end
        end
    end

    assign c_take = r_c_valid && (r_c_ent[REM_LO +: FIELD_BITS] != '0) &&
                    (!r_best_valid ||
                     (r_c_ent[DL_LO +: TIME_BITS] < r_best_ent[DL_LO +: TIME_BITS]));

    always_comb begin
        commit_ent = r_best_ent;
        commit_ent[REM_LO +: FIELD_BITS] = r_best_ent[REM_LO +: FIELD_BITS] - 1'b1;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_b_idx;
        wr_data = b_new;
        if ((r_state == SEQ_IDLE) && i_req.start && i_req.load) begin
            wr_en   = 1'b1;
            wr_addr = idx_ext[IDX_W-1:0];
            wr_data = load_ent;
        end else if (b_hit) begin
            wr_en = 1'b1;
        end else if ((r_state == SEQ_COMMIT) && !r_fail && r_best_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_best_idx;
            wr_data = commit_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_rsp.done     = 1'b0;
        o_rsp.fail     = r_fail;
        o_rsp.found    = r_best_valid;
        o_rsp.pick_idx = PICK_IDX_BITS'(r_best_idx);
        unique case (r_state)
            SEQ_IDLE: begin
                if (tick_start) begin
                    n_state = SEQ_SCAN;
                end
            end
            SEQ_SCAN: begin
                if ((r_issue == r_n) && !r_b_valid && !r_c_valid) begin
                    n_state = SEQ_COMMIT;
                end
            end
            SEQ_COMMIT: begin
                o_rsp.done = 1'b1;
                n_state    = SEQ_IDLE;
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= '0;
            r_issue      <= '0;
            r_fail       <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            r_b_valid <= rd_en;
            r_c_valid <= r_b_valid;
            if (rd_en) begin
                r_issue <= r_issue + 1'b1;
            end
            if (b_miss) begin
                r_fail <= 1'b1;
            end
            if (c_take) begin
                r_best_valid <= 1'b1;
            end
            if (tick_start) begin
                r_n          <= i_req.failed ? '0 : act_cnt;
                r_issue      <= '0;
                r_fail       <= i_req.failed;
                r_best_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_idx <= r_issue[IDX_W-1:0];
        r_c_idx <= r_b_idx;
        r_c_ent <= b_new;
        if (c_take) begin
            r_best_idx <= r_c_idx;
            r_best_ent <= r_c_ent;
        end
    end

    `EDFS_ASSERT_NEXT(a_done_idle, o_rsp.done, r_state == SEQ_IDLE, "scan did not return to idle")
    `EDFS_ASSERT_NOW(a_issue_bound, r_state == SEQ_SCAN, r_issue <= r_n, "read count overran task count")
    `EDFS_ASSERT_NOW(a_fail_src, (r_state == SEQ_SCAN) && ($past(r_state) == SEQ_SCAN) && $rose(r_fail), $past(r_b_valid), "miss raised without an entry in flight")

endmodule

FILE: design/edf_tick_scheduler_core.sv
// EDF tick scheduler. Load words (kind 0) write one task entry, reset the slot
// time and clear the failure flag; they give no result. Tick words (kind 1)
// release due tasks, pick the unfinished task with the earliest deadline
// (lowest index on ties) and return one result word. A tick passes through
// the accepting cycle, one entry memory with a single read port walked one
// task per cycle for task_count tasks (clamped to NUM_TASKS), the drain of
// the read and compare registers, the write-back of the picked task and the
// result hand-off. With task_count zero or after a failure no entry is read.
// While the output register still holds an unaccepted word, the tick waits
// at the hand-off. Configure task_count at APB address 0 only while idle.
`include "edf_tick_scheduler_core_macros.svh"

module edf_tick_scheduler_core
    import edfs_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_kind,
    input  logic [TASK_IDX_BITS-1:0] i_task_index,
    input  logic [FIELD_BITS-1:0]    i_period,
    input  logic [FIELD_BITS-1:0]    i_exec_time,

    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [OUT_TASK_BITS-1:0] o_scheduled_task,
    output logic                     o_failed,
    output logic [SLOT_BITS-1:0]     o_slot_time,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_top_state r_state, n_state;

    logic [COUNT_BITS-1:0]    r_task_count;
    logic [TIME_BITS-1:0]     r_time;
    logic                     r_failed;
    logic [OUT_TASK_BITS-1:0] r_res_task;
    logic                     r_res_failed;
    logic [SLOT_BITS-1:0]     r_res_slot;
    logic                     r_out_valid;
    logic [OUT_TASK_BITS-1:0] r_out_task;
    logic                     r_out_failed;
    logic [SLOT_BITS-1:0]     r_out_slot;

    logic                          in_acc;
    logic                          load_ok;
    logic                          cfg_wr;
    logic                          out_free;
    logic                          fail_now;
    logic                          res_load;
    logic [PICK_IDX_BITS:0]        pick_num;
    logic [TIME_BITS+SLOT_BITS-1:0] time_ext;
    t_seq_req                      seq_req;
    t_seq_rsp                      seq_rsp;

    edfs_seq #(
        .NUM_TASKS (NUM_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seq_req),
        .i_time  (r_time),
        .o_rsp   (seq_rsp)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign load_ok  = (32'(i_task_index) < NUM_TASKS);
    assign out_free = !r_out_valid || !i_out_stall;
    assign fail_now = r_failed || seq_rsp.fail;
    assign pick_num = {1'b0, seq_rsp.pick_idx} + 1'b1;
    assign time_ext = {{SLOT_BITS{1'b0}}, r_time};

    always_comb begin
        unique case (paddr[CFG_ADDR_BITS-1])
            REG_TASK_COUNT: prdata = CFG_DATA_BITS'(r_task_count);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TOP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_stall        = 1'b1;
        res_load          = 1'b0;
        seq_req.start     = 1'b0;
        seq_req.load      = (i_kind == KIND_LOAD);
        seq_req.idx       = i_task_index;
        seq_req.period    = i_period;
        seq_req.exec_time = i_exec_time;
        seq_req.count     = r_task_count;
        seq_req.failed    = r_failed;
        unique case (r_state)
            TOP_IDLE: begin
                o_in_stall    = 1'b0;
                seq_req.start = in_acc && ((i_kind == KIND_TICK) || load_ok);
                if (in_acc && (i_kind == KIND_TICK)) begin
                    n_state = TOP_BUSY;
                end
            end
            TOP_BUSY: begin
                if (seq_rsp.done) begin
                    n_state = TOP_DONE;
                end
            end
            TOP_DONE: begin
                if (out_free) begin
                    res_load = 1'b1;
                    n_state  = TOP_IDLE;
                end
            end
            default: begin
                n_state = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= RESET_TASK_COUNT;
            r_time       <= '0;
            r_failed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[CFG_ADDR_BITS-1] == REG_TASK_COUNT)) begin
                r_task_count <= pwdata[COUNT_BITS-1:0];
            end
            if (in_acc && (i_kind == KIND_LOAD) && load_ok) begin
                r_time   <= '0;
                r_failed <= 1'b0;
            end
            if ((r_state == TOP_BUSY) && seq_rsp.done) begin
                r_failed <= fail_now;
                if (!fail_now && (r_time != '1)) begin
                    r_time <= r_time + 1'b1;
                end
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == TOP_BUSY) && seq_rsp.done) begin
            r_res_failed <= fail_now;
            r_res_slot   <= time_ext[SLOT_BITS-1:0];
            if (fail_now || !seq_rsp.found) begin
                r_res_task <= '0;
            end else begin
                r_res_task <= pick_num[OUT_TASK_BITS-1:0];
            end
        end
        if (res_load) begin
            r_out_task   <= r_res_task;
            r_out_failed <= r_res_failed;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_scheduled_task = r_out_task;
    assign o_failed         = r_out_failed;
    assign o_slot_time      = r_out_slot;

    `EDFS_ASSERT_NEXT(a_fail_sticky,
        r_failed && !(in_acc && (i_kind == KIND_LOAD) && load_ok),
        r_failed, "failure flag dropped without a load")
    `EDFS_ASSERT_NEXT(a_time_step,
        (r_state == TOP_BUSY) && seq_rsp.done && !fail_now && (r_time != '1),
        r_time == $past(r_time) + 1'b1, "slot time did not advance")
    `EDFS_ASSERT_NOW(a_fail_idle, r_out_valid && r_out_failed, r_out_task == '0,
        "failed slot reports a task")

endmodule
